// ===== src/wlqe_pkg.sv =====
// Package: shared constants for the wide line quad expander.
`timescale 1ns / 1ps
package wlqe_pkg;
    localparam int WIDTH_BITS = 8;
    localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
endpackage

// ===== src/wide_line_quad_expander.sv =====
// Top level: wide line quad expander with APB config and stream ports.
// A join-only or straight segment shows its join vertex the cycle after accept.
// A general segment first runs two offset searches (load, square, then square
// and compare for each of 13 result bits, done) with the ST_WAITX turnaround
// between them; its join shows once both are done. New requests are taken only in ST_IDLE.
// Reset: synchronous active-low aresetn; line_width 1, no previous point.
`timescale 1ns / 1ps
module wide_line_quad_expander import wlqe_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: point_x, point_y (low up), zero filled to bytes
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: line_start
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: vertex_x, vertex_y (low up), zero filled to bytes
    output logic [((2*(COORD_BITS+FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
    // tuser: vertex_kind
    output logic        m_tuser,
    // tlast: last_of_item
    output logic        m_tlast
);
    localparam int VB = COORD_BITS + FRAC_BITS + 1;
    localparam int OB = WIDTH_BITS + FRAC_BITS + 1;
    localparam int OUTW = ((2*VB+7)/8)*8;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_RX = 3'd1, ST_RY = 3'd2,
                           ST_EMIT = 3'd3, ST_WAITX = 3'd4;

    logic [WIDTH_BITS-1:0] width_reg;
    logic [2:0] state_reg;
    logic [2:0] cnt_reg;
    logic       quad_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg, cx_reg, cy_reg;
    logic       prev_valid_reg;
    logic signed [VB-1:0] ox_reg, oy_reg;
    logic       neg_ox_reg;
    logic [COORD_BITS:0] adx_reg, ady_reg;
    logic [2*COORD_BITS+2:0] d2_reg;
    logic       ou_start, ou_busy, ou_done;
    logic [OB-1:0] ou_res;
    logic [COORD_BITS:0] ou_mag;
    logic signed [COORD_BITS-1:0] px_keep, py_keep;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LINE_WIDTH) ? 32'(width_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) width_reg <= WIDTH_BITS'(1);
        else if (psel && penable && pwrite && paddr == REG_LINE_WIDTH)
            width_reg <= pwdata[WIDTH_BITS-1:0];
    end

    // one search per offset: x side with |dy|, then y side with |dx|
    assign s_tready = (state_reg == ST_IDLE);
    assign ou_start = (state_reg == ST_RX || state_reg == ST_RY) && !ou_busy && !ou_done;
    assign ou_mag = (state_reg == ST_RX) ? ady_reg : adx_reg;

    wlqe_offset_unit #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ofs (
        .aclk(aclk), .aresetn(aresetn), .start(ou_start), .line_width(width_reg),
        .mag(ou_mag), .d2(d2_reg), .busy(ou_busy), .done(ou_done), .result(ou_res)
    );

    // segment vector, computed at accept
    logic signed [COORD_BITS:0] in_x, in_y, dx, dy;
    assign in_x = (COORD_BITS+1)'($signed(s_tdata[COORD_BITS-1:0]));
    assign in_y = (COORD_BITS+1)'($signed(s_tdata[2*COORD_BITS-1:COORD_BITS]));
    assign dx = in_x - (COORD_BITS+1)'(prev_x_reg);
    assign dy = in_y - (COORD_BITS+1)'(prev_y_reg);
    logic [COORD_BITS:0] adx, ady;
    assign adx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
    assign ady = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
    logic signed [VB-1:0] half;
    assign half = VB'(width_reg >> 1) << FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            prev_valid_reg <= 1'b0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            cnt_reg <= '0;
            quad_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    cx_reg <= in_x[COORD_BITS-1:0];
                    cy_reg <= in_y[COORD_BITS-1:0];
                    prev_x_reg <= in_x[COORD_BITS-1:0];
                    prev_y_reg <= in_y[COORD_BITS-1:0];
                    prev_valid_reg <= 1'b1;
                    quad_reg <= !s_tuser && prev_valid_reg;
                    cnt_reg <= '0;
                    adx_reg <= adx;
                    ady_reg <= ady;
                    d2_reg <= (2*COORD_BITS+3)'(adx) * (2*COORD_BITS+3)'(adx)
                            + (2*COORD_BITS+3)'(ady) * (2*COORD_BITS+3)'(ady);
                    neg_ox_reg <= (dx > 0) == (dy > 0);
                    // v1 side of quad: px+ox, py+oy (cx_reg's prev kept below)
                    ox_reg <= (dx == 0) ? -half : '0;
                    oy_reg <= (dx == 0) ? '0 : half;
                    if (!s_tuser && prev_valid_reg && dx != 0 && dy != 0)
                        state_reg <= ST_RX;
                    else state_reg <= ST_EMIT;
                    px_keep <= prev_x_reg;
                    py_keep <= prev_y_reg;
                end
                ST_RX: if (ou_done) begin
                    ox_reg <= neg_ox_reg ? -VB'(ou_res) : VB'(ou_res);
                    state_reg <= ST_WAITX;
                end
                ST_WAITX: state_reg <= ST_RY;
                ST_RY: if (ou_done) begin
                    oy_reg <= VB'(ou_res);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: if (m_tready) begin
                    if (!quad_reg || cnt_reg == 3'd6) state_reg <= ST_IDLE;
                    else cnt_reg <= cnt_reg + 3'd1;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    logic signed [VB-1:0] pxs, pys, qxs, qys, vx, vy;
    assign pxs = VB'(px_keep) <<< FRAC_BITS;
    assign pys = VB'(py_keep) <<< FRAC_BITS;
    assign qxs = VB'(cx_reg) <<< FRAC_BITS;
    assign qys = VB'(cy_reg) <<< FRAC_BITS;

    // order: join, v1, v2, v3, v3, v2, v4
    always_comb begin
        case (cnt_reg)
            3'd0: begin vx = qxs; vy = qys; end
            3'd1: begin vx = pxs + ox_reg; vy = pys + oy_reg; end
            3'd2, 3'd5: begin vx = pxs - ox_reg; vy = pys - oy_reg; end
            3'd3, 3'd4: begin vx = qxs + ox_reg; vy = qys + oy_reg; end
            default: begin vx = qxs - ox_reg; vy = qys - oy_reg; end
        endcase
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata = OUTW'({vy, vx});
    assign m_tuser = (cnt_reg != 3'd0);
    assign m_tlast = !quad_reg || cnt_reg == 3'd6;
endmodule

// ===== src/wlqe_offset_unit.sv =====
// Offset unit: iterative bit-search for round(w*2^F*mag/(2*sqrt(d2))).
`timescale 1ns / 1ps
module wlqe_offset_unit import wlqe_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [WIDTH_BITS-1:0]         line_width,
    input  logic [COORD_BITS:0]           mag,
    input  logic [2*COORD_BITS+2:0]       d2,
    output logic                          busy,
    output logic                          done,
    output logic [WIDTH_BITS+FRAC_BITS:0] result
);
    localparam int SB = WIDTH_BITS + FRAC_BITS + 1;
    localparam int PB = WIDTH_BITS + FRAC_BITS + COORD_BITS + 1;
    localparam int CB = $clog2(SB + 1);
    localparam int QB = 2 * SB + 2 * COORD_BITS + 3;
    localparam int TB = (2 * PB > QB) ? 2 * PB : QB;

    logic [PB-1:0]   p_reg;
    logic [TB-1:0]   psq_reg;
    logic [2*COORD_BITS+2:0] d2_reg;
    logic [SB-1:0]   m_reg, m_next;
    logic [CB-1:0]   bit_reg;
    logic [1:0]      phase_reg;
    logic            busy_reg, done_reg;
    logic [SB-1:0]   cand;
    logic [2*SB-1:0] csq_reg;
    logic [TB-1:0]   prod;

    // phase 0: square p; then per bit: square candidate, then compare
    assign cand = m_reg | (SB'(1) << bit_reg);
    assign prod = TB'(csq_reg) * TB'(d2_reg);
    assign m_next = (prod <= psq_reg) ? cand : m_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            phase_reg <= 2'd0;
            bit_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                phase_reg <= 2'd0;
                bit_reg <= CB'(SB - 1);
                m_reg <= '0;
                p_reg <= (PB'(line_width) << FRAC_BITS) * PB'(mag);
                d2_reg <= d2;
            end else if (busy_reg) begin
                case (phase_reg)
                    2'd0: begin
                        psq_reg <= TB'(p_reg) * TB'(p_reg);
                        phase_reg <= 2'd1;
                    end
                    2'd1: begin
                        csq_reg <= (2*SB)'(cand) * (2*SB)'(cand);
                        phase_reg <= 2'd2;
                    end
                    default: begin
                        m_reg <= m_next;
                        phase_reg <= 2'd1;
                        if (bit_reg == '0) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end else begin
                            bit_reg <= bit_reg - CB'(1);
                        end
                    end
                endcase
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign result = SB'((m_reg + SB'(1)) >> 1);
endmodule
